### design/wsq_pkg.sv
// Shared types, codes and default sizes for the work-stealing deque block.
package wsq_pkg;

  // Default sizes handed to the top level parameters.
  localparam int CPUS_DEF  = 4;
  localparam int SLOTS_DEF = 128;

  // Fixed payload widths of the channels.
  localparam int HANDLE_W = 32;
  localparam int REQ_W    = 2;
  localparam int VIC_W    = 2;
  localparam int STATUS_W = 3;
  localparam int SRC_W    = 2;

  // Request kinds.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PUSHED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STOLEN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOWORK = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_READ,
    S_DONE
  } seq_state_t;

  // Which index of the selected deque addresses the slot memory.
  typedef enum logic [1:0] {
    VIEW_HEAD,
    VIEW_HEAD_DEC,
    VIEW_TAIL
  } view_t;

  // Command from the sequencer to the index unit.
  typedef struct packed {
    view_t view;
    logic  upd;
  } ptr_cmd_t;

  // Occupancy flags of the selected deque.
  typedef struct packed {
    logic empty;
    logic full;
  } occ_stat_t;

endpackage

### design/wsq_if.sv
// Valid/ready channel interfaces for requests and results.
interface wsq_in_if;
  import wsq_pkg::*;

  logic                valid;
  logic                ready;
  logic                req_type;
  logic [REQ_W-1:0]    requester;
  logic [HANDLE_W-1:0] handle_in;
  logic [VIC_W-1:0]    victim_start;

  modport source (output valid, req_type, requester, handle_in, victim_start, input ready);
  modport sink   (input valid, req_type, requester, handle_in, victim_start, output ready);
endinterface

interface wsq_out_if;
  import wsq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle_out;
  logic [SRC_W-1:0]    source_cpu;

  modport source (output valid, status, handle_out, source_cpu, input ready);
  modport sink   (input valid, status, handle_out, source_cpu, output ready);
endinterface

### design/wsq_slot_ram.sv
// Single-port handle memory with registered read data.
module wsq_slot_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write when asked; the read port samples the same address every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

endmodule

### design/wsq_ptr_unit.sv
// Head and tail indexes of every deque, with the shared occupancy and address unit.
module wsq_ptr_unit #(
  parameter int CPUS  = wsq_pkg::CPUS_DEF,
  parameter int SLOTS = wsq_pkg::SLOTS_DEF,
  localparam int CW   = $clog2(CPUS),
  localparam int IW   = $clog2(2 * SLOTS),
  localparam int SW   = $clog2(SLOTS),
  localparam int AW   = $clog2(CPUS * SLOTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CW-1:0]      cpu,
  input  wsq_pkg::ptr_cmd_t  cmd,
  output wsq_pkg::occ_stat_t stat,
  output logic [AW-1:0]      addr
);
  import wsq_pkg::*;

  localparam logic [IW-1:0] IDX_LAST = IW'(2 * SLOTS - 1);
  localparam logic [IW-1:0] IDX_SPAN = IW'(2 * SLOTS);
  localparam logic [IW-1:0] IDX_SLOTS = IW'(SLOTS);

  logic [IW-1:0] head_r [CPUS];
  logic [IW-1:0] tail_r [CPUS];

  logic [IW-1:0] h, t, occ, h_inc, h_dec, t_inc, idx, slot_full;
  logic [SW-1:0] slot;

  // Occupancy of the selected deque, counted modulo twice the slot count.
  always_comb begin
    h   = head_r[cpu];
    t   = tail_r[cpu];
    occ = (h >= t) ? (h - t) : (h + IDX_SPAN - t);
    stat.empty = (h == t);
    stat.full  = (occ >= IDX_SLOTS);
    h_inc = (h == IDX_LAST) ? '0 : h + 1'b1;
    h_dec = (h == '0) ? IDX_LAST : h - 1'b1;
    t_inc = (t == IDX_LAST) ? '0 : t + 1'b1;
  end

  // Slot address of the chosen index.
  always_comb begin
    unique case (cmd.view)
      VIEW_HEAD:     idx = h;
      VIEW_HEAD_DEC: idx = h_dec;
      VIEW_TAIL:     idx = t;
      default:       idx = h;
    endcase
    slot_full = (idx >= IDX_SLOTS) ? (idx - IDX_SLOTS) : idx;
    slot      = SW'(slot_full);
    addr      = AW'(cpu) * AW'(SLOTS) + AW'(slot);
  end

  // Index update of the selected deque.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CPUS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else if (cmd.upd) begin
      unique case (cmd.view)
        VIEW_HEAD:     head_r[cpu] <= h_inc;
        VIEW_HEAD_DEC: head_r[cpu] <= h_dec;
        VIEW_TAIL:     tail_r[cpu] <= t_inc;
        default:       head_r[cpu] <= h;
      endcase
    end
  end

endmodule

### design/work_stealing_queues_top.sv
// Per-CPU work-stealing deques: top level with the request sequencer and result register.
// One bounded ring deque of work handles is kept for each CPU. A push adds the handle at the
// head of the requester's deque or reports full; a take pops the newest handle of the
// requester's own deque, otherwise steals the oldest handle of the first non-empty other
// deque, scanning from victim_start and wrapping. Requests are handled one at a time and
// in_ready is low while one is in progress. After acceptance the requester's deque is checked;
// a push then finishes, an own pop reads the memory, and a take that goes to the other deques
// examines up to CPUS of them, reading the memory if it steals. The single index unit examines
// one deque per cycle, and the single memory port has registered read data. A result waiting
// on out_ch holds the sequencer until the result register is free.
// Requester and victim_start are taken modulo CPUS. No clearing pass follows reset.
module work_stealing_queues_top #(
  parameter int CPUS  = wsq_pkg::CPUS_DEF,
  parameter int SLOTS = wsq_pkg::SLOTS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  wsq_in_if.sink   in_ch,
  wsq_out_if.source out_ch
);
  import wsq_pkg::*;

  localparam int CW = $clog2(CPUS);
  localparam int AW = $clog2(CPUS * SLOTS);
  localparam logic [CW-1:0] CPU_LAST = CW'(CPUS - 1);

  seq_state_t state_r, state_nxt;

  logic                kind_r;
  logic [CW-1:0]       me_r, vic_r, cnt_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [STATUS_W-1:0] status_r;
  logic [CW-1:0]       src_r;
  logic                from_mem_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [SRC_W-1:0]    out_src_r;

  logic [CW-1:0]       me_in, vic_in, cpu_sel, vic_next;
  ptr_cmd_t            cmd;
  occ_stat_t           stat;
  logic [AW-1:0]       addr;
  logic                ram_we;
  logic [HANDLE_W-1:0] rdata;
  logic                hit, scan_last, out_free;

  // Request fields reduced modulo the CPU count.
  always_comb begin
    me_in  = (32'(in_ch.requester) >= CPUS) ?
             CW'(32'(in_ch.requester) - CPUS) : CW'(in_ch.requester);
    vic_in = (32'(in_ch.victim_start) >= CPUS) ?
             CW'(32'(in_ch.victim_start) - CPUS) : CW'(in_ch.victim_start);
  end

  assign hit       = (vic_r != me_r) && !stat.empty;
  assign scan_last = (cnt_r == CPU_LAST);
  assign vic_next  = (vic_r == CPU_LAST) ? '0 : vic_r + 1'b1;
  assign out_free  = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (kind_r == REQ_PUSH) state_nxt = S_DONE;
        else if (!stat.empty)   state_nxt = S_READ;
        else                    state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit)            state_nxt = S_READ;
        else if (scan_last) state_nxt = S_DONE;
      end
      S_READ:  state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: deque selection, index command and memory write.
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    cpu_sel     = me_r;
    cmd.view    = VIEW_HEAD;
    cmd.upd     = 1'b0;
    ram_we      = 1'b0;
    unique case (state_r)
      S_CHECK: begin
        if (kind_r == REQ_PUSH) begin
          cmd.view = VIEW_HEAD;
          cmd.upd  = !stat.full;
          ram_we   = !stat.full;
        end else begin
          cmd.view = VIEW_HEAD_DEC;
          cmd.upd  = !stat.empty;
        end
      end
      S_SCAN: begin
        cpu_sel  = vic_r;
        cmd.view = VIEW_TAIL;
        cmd.upd  = hit;
      end
      default: begin
        cpu_sel = me_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request and result bookkeeping.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_r   <= in_ch.req_type;
          me_r     <= me_in;
          handle_r <= in_ch.handle_in;
          vic_r    <= vic_in;
          cnt_r    <= '0;
        end
      end
      S_CHECK: begin
        if (kind_r == REQ_PUSH) begin
          status_r   <= stat.full ? ST_FULL : ST_PUSHED;
          src_r      <= '0;
          from_mem_r <= 1'b0;
        end else if (!stat.empty) begin
          status_r   <= ST_POPPED;
          src_r      <= me_r;
          from_mem_r <= 1'b1;
        end
      end
      S_SCAN: begin
        if (hit) begin
          status_r   <= ST_STOLEN;
          src_r      <= vic_r;
          from_mem_r <= 1'b1;
        end else begin
          vic_r <= vic_next;
          cnt_r <= cnt_r + 1'b1;
          if (scan_last) begin
            status_r   <= ST_NOWORK;
            src_r      <= '0;
            from_mem_r <= 1'b0;
          end
        end
      end
      S_READ: begin
        handle_r <= rdata;
      end
      default: begin
        handle_r <= handle_r;
      end
    endcase
  end

  // Result register: loads when the result slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_status_r <= status_r;
      out_handle_r <= from_mem_r ? handle_r : '0;
      out_src_r    <= SRC_W'(src_r);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.handle_out = out_handle_r;
  assign out_ch.source_cpu = out_src_r;

  wsq_ptr_unit #(
    .CPUS  (CPUS),
    .SLOTS (SLOTS)
  ) u_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .cpu   (cpu_sel),
    .cmd   (cmd),
    .stat  (stat),
    .addr  (addr)
  );

  wsq_slot_ram #(
    .DEPTH (CPUS * SLOTS),
    .WIDTH (HANDLE_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .addr    (addr),
    .wdata   (handle_r),
    .rdata_r (rdata)
  );

endmodule

### design/wsq_checker.sv
// Port-level checks of the work-stealing deque block, bound to its top level.
module wsq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [wsq_pkg::STATUS_W-1:0] out_status,
  input logic [wsq_pkg::HANDLE_W-1:0] out_handle,
  input logic [wsq_pkg::SRC_W-1:0]    out_source
);
  import wsq_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_handle) && $stable(out_source))
    else $error("stalled result changed or dropped");

  // The block is busy in the cycle after a request transfer.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Results that take no handle carry zero handle and source.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_PUSHED || out_status == ST_FULL ||
      out_status == ST_NOWORK) |-> out_handle == '0 && out_source == '0)
    else $error("handle or source set on a result without a handle");

  // A new result appears only at the end of a request in progress.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind work_stealing_queues_top wsq_checker u_wsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_handle (out_ch.handle_out),
  .out_source (out_ch.source_cpu)
);
